// ===== src/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
package sacl_pkg;

    // Access kinds
    localparam logic [1:0] MODE_INSTR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_STORE  = 2'd2;
    localparam logic [1:0] MODE_MODIFY = 2'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_USED  = 2'd2;

    // Field widths
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_USED_W  = 4;
    localparam int COUNT_W      = 32;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
    } sacl_req_t;

    typedef struct packed {
        logic               was_hit;
        logic               was_miss;
        logic               was_evicted;
        logic               extra_hit;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
    } sacl_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic clear;
    } sacl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } sacl_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } sacl_state_t;

endpackage

// ===== src/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sacl_ctrl.sv =====
// Sequencing state machine: clearing pass, accept, lookup.
module sacl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sacl_pkg::sacl_status_t status,
    output sacl_pkg::sacl_cmd_t    cmd,
    output logic                  busy
);
    import sacl_pkg::*;

    sacl_state_t state_reg;
    sacl_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/sacl_dpath.sv =====
// Datapath: address split, set RAM, way compare, LRU update and totals.
module sacl_dpath #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sacl_pkg::sacl_cmd_t                   cmd,
    output sacl_pkg::sacl_status_t                status,
    input  sacl_pkg::sacl_req_t                   req,
    input  logic                                  cfg_valid,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]       cfg_data,
    output sacl_pkg::sacl_rsp_t                   rsp,
    output logic                                  rsp_valid
);
    import sacl_pkg::*;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    typedef struct packed {
        logic                  valid;
        logic [RANK_W-1:0]     rank;
        logic [ADDR_WIDTH-1:0] tag;
    } way_t;

    localparam int ROW_W = WAYS * $bits(way_t);

    // Configuration
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_USED_W-1:0]  ways_used_reg;

    // Access registers
    logic [1:0]            mode_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic [SET_W-1:0]      clr_row_reg;

    // Totals and result
    logic [COUNT_W-1:0] hit_total_reg;
    logic [COUNT_W-1:0] miss_total_reg;
    logic [COUNT_W-1:0] evict_total_reg;
    logic [COUNT_W-1:0] hit_total_next;
    logic [COUNT_W-1:0] miss_total_next;
    logic [COUNT_W-1:0] evict_total_next;
    sacl_rsp_t          rsp_reg;
    sacl_rsp_t          rsp_next;
    logic               rsp_valid_reg;

    // Address split
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [3:0]            set_eff;
    logic [6:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic [ADDR_WIDTH-1:0] idx_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;

    // Set RAM
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    way_t [WAYS-1:0]  row_rd;
    way_t [WAYS-1:0]  row_wr;

    // Lookup
    logic [WAYS-1:0]      in_use;
    logic [WAYS-1:0]      inv_vec;
    logic [WAYS-1:0]      match_vec;
    logic                 hit_any;
    logic                 any_inv;
    logic [WAY_IDX_W-1:0] found_idx;
    logic [WAY_IDX_W-1:0] empty_idx;
    logic [WAY_IDX_W-1:0] vic_idx;
    logic [WAY_IDX_W-1:0] target_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [RANK_W-1:0]    old_rank;
    logic                 is_data;
    logic                 hit_flag;
    logic                 miss_flag;
    logic                 evict_flag;
    logic                 extra_flag;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_used_reg  <= WAYS_USED_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS_USED:  ways_used_reg  <= cfg_data[WAYS_USED_W-1:0];
                default:        ;
            endcase
        end
    end

    // Split the incoming address into tag and set index
    always_comb
    begin
        addr_in     = req.address[ADDR_WIDTH-1:0];
        set_eff     = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                             : 4'(set_bits_reg);
        tag_shift   = 7'(set_eff) + 7'(block_bits_reg);
        tag_in      = addr_in >> tag_shift;
        idx_shifted = addr_in >> block_bits_reg;
        set_mask    = (SET_W'(1) << set_eff) - SET_W'(1);
        set_in      = idx_shifted[SET_W-1:0] & set_mask;
    end

    // Latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req.mode;
            tag_reg  <= tag_in;
            set_reg  <= set_in;
        end
    end

    // Advance the clearing row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_row_reg <= clr_row_reg + SET_W'(1);
        end
    end

    assign status.clear_last = (clr_row_reg == SET_W'(NUM_SETS - 1));

    assign row_rd = ram_rdata;

    // Per-way valid, free and match flags
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (ways_used_reg == '0)
            begin
                in_use[w] = (w == 0);
            end
            else
            begin
                in_use[w] = ({1'b0, ways_used_reg} > 5'(w));
            end
            inv_vec[w]   = in_use[w] & ~row_rd[w].valid;
            match_vec[w] = in_use[w] & row_rd[w].valid & (row_rd[w].tag == tag_reg);
        end
    end

    // Pick the target way: hit, first free, or least recently used
    always_comb
    begin
        found_idx = '0;
        empty_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_vec[w])
            begin
                found_idx = WAY_IDX_W'(w);
            end
            if (inv_vec[w])
            begin
                empty_idx = WAY_IDX_W'(w);
            end
        end
        vic_idx   = '0;
        best_rank = row_rd[0].rank;
        for (int w = 1; w < WAYS; w++)
        begin
            if (in_use[w] && (row_rd[w].rank > best_rank))
            begin
                best_rank = row_rd[w].rank;
                vic_idx   = WAY_IDX_W'(w);
            end
        end
        hit_any    = |match_vec;
        any_inv    = |inv_vec;
        target_idx = hit_any ? found_idx : (any_inv ? empty_idx : vic_idx);
        old_rank   = row_rd[target_idx].rank;
    end

    // Age newer valid ways (all on a miss); install target as newest
    always_comb
    begin
        row_wr = row_rd;
        for (int w = 0; w < WAYS; w++)
        begin
            if (in_use[w] && row_rd[w].valid && (WAY_IDX_W'(w) != target_idx)
                && (!hit_any || (row_rd[w].rank < old_rank))
                && (row_rd[w].rank < RANK_MAX))
            begin
                row_wr[w].rank = row_rd[w].rank + RANK_W'(1);
            end
        end
        row_wr[target_idx].valid = 1'b1;
        row_wr[target_idx].rank  = '0;
        row_wr[target_idx].tag   = tag_reg;
    end

    // Result flags and totals
    always_comb
    begin
        is_data    = (mode_reg != MODE_INSTR);
        hit_flag   = is_data & hit_any;
        miss_flag  = is_data & ~hit_any;
        evict_flag = is_data & ~hit_any & ~any_inv;
        extra_flag = (mode_reg == MODE_MODIFY);

        hit_total_next   = hit_total_reg + COUNT_W'(hit_flag) + COUNT_W'(extra_flag);
        miss_total_next  = miss_total_reg + COUNT_W'(miss_flag);
        evict_total_next = evict_total_reg + COUNT_W'(evict_flag);

        rsp_next.was_hit        = hit_flag;
        rsp_next.was_miss       = miss_flag;
        rsp_next.was_evicted    = evict_flag;
        rsp_next.extra_hit      = extra_flag;
        rsp_next.hit_total      = hit_total_next;
        rsp_next.miss_total     = miss_total_next;
        rsp_next.eviction_total = evict_total_next;
    end

    // Update totals and strobe the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= cmd.lookup;
            if (cmd.lookup)
            begin
                hit_total_reg   <= hit_total_next;
                miss_total_reg  <= miss_total_next;
                evict_total_reg <= evict_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Write back the set, or zero a row during the clearing pass
    always_comb
    begin
        ram_we    = cmd.clear | (cmd.lookup & is_data);
        ram_waddr = cmd.clear ? clr_row_reg : set_reg;
        ram_wdata = cmd.clear ? '0 : ROW_W'(row_wr);
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS),
        .AW    (SET_W)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

endmodule

// ===== src/set_assoc_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache model.
//
// Usage: a word (access kind and 64-bit address) is taken at a rising edge
// with start high and busy low. The block looks up the set, updates it and
// returns one result word on rsp, marked by rsp_valid for exactly one cycle.
// Result: hit/miss/eviction flags, the modify extra hit and running totals.
// After the accepting edge the block enters the LOOKUP state; the result
// strobe is registered from it. busy is high in LOOKUP, while the set RAM read
// data is compared and the updated row written back; no word is taken then.
// The next word may be taken in the same cycle the previous result shows.
// Instruction fetches return zero flags and the current totals.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write it only while idle.
// Reset: rst_n resets totals and configuration, then a clearing pass zeroes
// one set row per cycle, all 2**MAX_SET_BITS rows (64 by default), with busy
// high. The receiver cannot stall: each result must be taken when strobed.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  sacl_pkg::sacl_req_t              req,
    output logic                             rsp_valid,
    output sacl_pkg::sacl_rsp_t              rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sacl_pkg::*;

    sacl_cmd_t    cmd;
    sacl_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sacl_dpath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the set-associative LRU cache model.
module tb;
    import sacl_pkg::*;

    localparam int SET_MAX   = 6;
    localparam int LINE_WAYS = 8;
    localparam int NUM_SETS  = 1 << SET_MAX;
    localparam logic [2:0] RANK_MAX = 3'(LINE_WAYS - 1);
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int PHASES = 10;
    localparam int PHASE_ACCESSES = 55;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sacl_req_t req;
    logic rsp_valid;
    sacl_rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the cache contents and settings
    logic [SET_BITS_W-1:0] mdl_set_bits = '0;
    logic [BLOCK_BITS_W-1:0] mdl_block_bits = '0;
    logic [WAYS_USED_W-1:0] mdl_ways = 4'd1;
    bit mdl_valid[NUM_SETS][LINE_WAYS] = '{default: 0};
    logic [63:0] mdl_tag[NUM_SETS][LINE_WAYS];
    logic [2:0] mdl_rank[NUM_SETS][LINE_WAYS] = '{default: '0};
    logic [COUNT_W-1:0] hit_count = '0;
    logic [COUNT_W-1:0] miss_count = '0;
    logic [COUNT_W-1:0] evict_count = '0;

    sacl_rsp_t predicted[$];
    int fail_count = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS(SET_MAX),
        .WAYS(LINE_WAYS),
        .ADDR_WIDTH(64)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Make way w most recent; age newer ways, or all valid ones on a fill
    function automatic void promote(int set_idx, int nw, int w, bit was_valid);
        logic [2:0] old;
        old = mdl_rank[set_idx][w];
        for (int v = 0; v < nw; v++)
        begin
            if (v != w && mdl_valid[set_idx][v] && (!was_valid || mdl_rank[set_idx][v] < old)
                && mdl_rank[set_idx][v] != RANK_MAX)
                mdl_rank[set_idx][v]++;
        end
        mdl_rank[set_idx][w] = '0;
    endfunction

    // Look up one access, update the mirror and return the expected word
    function automatic sacl_rsp_t lookup_access(sacl_req_t a);
        sacl_rsp_t r;
        int s;
        int b;
        int nw;
        int set_idx;
        int hit_way;
        int empty_way;
        int victim;
        logic [63:0] tag;
        r = '0;
        if (a.mode != MODE_INSTR)
        begin
            s = (mdl_set_bits > SET_MAX) ? SET_MAX : int'(mdl_set_bits);
            b = mdl_block_bits;
            nw = (mdl_ways == 0) ? 1 : ((mdl_ways > LINE_WAYS) ? LINE_WAYS : int'(mdl_ways));
            tag = (s + b >= 64) ? 64'd0 : (a.address >> (s + b));
            set_idx = int'((a.address >> b) & ((64'd1 << s) - 64'd1));
            hit_way = nw;
            empty_way = nw;
            for (int w = 0; w < nw; w++)
            begin
                if (!mdl_valid[set_idx][w])
                begin
                    if (empty_way == nw)
                        empty_way = w;
                end
                else if (mdl_tag[set_idx][w] == tag)
                begin
                    hit_way = w;
                    break;
                end
            end
            if (hit_way < nw)
            begin
                r.was_hit = 1'b1;
                promote(set_idx, nw, hit_way, 1'b1);
            end
            else
            begin
                r.was_miss = 1'b1;
                if (empty_way < nw)
                    victim = empty_way;
                else
                begin
                    // oldest valid way wins, lowest way on a tie
                    victim = 0;
                    for (int w = 1; w < nw; w++)
                        if (mdl_rank[set_idx][w] > mdl_rank[set_idx][victim])
                            victim = w;
                    r.was_evicted = 1'b1;
                end
                promote(set_idx, nw, victim, 1'b0);
                mdl_valid[set_idx][victim] = 1'b1;
                mdl_tag[set_idx][victim] = tag;
            end
            r.extra_hit = (a.mode == MODE_MODIFY);
            hit_count += COUNT_W'(r.was_hit) + COUNT_W'(r.extra_hit);
            miss_count += COUNT_W'(r.was_miss);
            evict_count += COUNT_W'(r.was_evicted);
        end
        r.hit_total = hit_count;
        r.miss_total = miss_count;
        r.eviction_total = evict_count;
        return r;
    endfunction

    // Build an address from tag, set and offset under the current settings
    function automatic logic [63:0] make_addr(logic [63:0] tag, int set_idx, logic [63:0] off);
        int s;
        int b;
        logic [63:0] a;
        s = (mdl_set_bits > SET_MAX) ? SET_MAX : int'(mdl_set_bits);
        b = mdl_block_bits;
        a = (s + b >= 64) ? 64'd0 : (tag << (s + b));
        a = a | (64'(set_idx) << b) | (off & ((64'd1 << b) - 64'd1));
        return a;
    endfunction

    // Drop start and wait a number of cycles
    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one word, wait for it to be taken, then maybe idle
    task automatic send_access(input logic [1:0] kind, input logic [63:0] addr);
        sacl_req_t item;
        item.mode = kind;
        item.address = addr;
        start <= 1'b1;
        req <= item;
        do @(posedge clk); while (busy);
        predicted.push_back(lookup_access(item));
        if (gaps_on && $urandom_range(0, 99) < 34)
            hold_off($urandom_range(1, 4));
    endtask

    // Wait until every expected word has arrived and the block is quiet
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (predicted.size() != 0 || busy);
        repeat (3) @(posedge clk);
    endtask

    // Write one register and mirror it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SET_BITS:   mdl_set_bits = data[SET_BITS_W-1:0];
            CFG_BLOCK_BITS: mdl_block_bits = data[BLOCK_BITS_W-1:0];
            CFG_WAYS_USED:  mdl_ways = data[WAYS_USED_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        sacl_rsp_t want;
        if (rst_n && rsp_valid)
        begin
            if (predicted.size() == 0)
            begin
                $display("%0t: result word with none expected: %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = predicted.pop_front();
                check_field("was_hit", 32'(want.was_hit), 32'(rsp.was_hit));
                check_field("was_miss", 32'(want.was_miss), 32'(rsp.was_miss));
                check_field("was_evicted", 32'(want.was_evicted), 32'(rsp.was_evicted));
                check_field("extra_hit", 32'(want.extra_hit), 32'(rsp.extra_hit));
                check_field("hit_total", want.hit_total, rsp.hit_total);
                check_field("miss_total", want.miss_total, rsp.miss_total);
                check_field("eviction_total", want.eviction_total, rsp.eviction_total);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words outstanding", $time, predicted.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset settings: one way, no set bits, every address is its own tag
    task automatic test_reset_defaults();
        send_access(MODE_INSTR, 64'd0);
        send_access(MODE_LOAD, 64'd0);
        send_access(MODE_LOAD, 64'd0);
        send_access(MODE_STORE, '1);
        send_access(MODE_MODIFY, '1);
        send_access(MODE_INSTR, '1);
        send_access(MODE_MODIFY, 64'h5555_5555_5555_5555);
    endtask

    // Out-of-range settings and offset plus index covering the whole address
    task automatic test_register_extremes();
        settle();
        write_reg(CFG_SET_BITS, 6'h3f);
        write_reg(CFG_BLOCK_BITS, 6'h3f);
        write_reg(CFG_WAYS_USED, 6'h0f);
        send_access(MODE_LOAD, 64'd0);
        send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
        send_access(MODE_STORE, '1);
        send_access(MODE_MODIFY, 64'h7fff_ffff_ffff_ffff);
        settle();
        write_reg(CFG_UNUSED, 6'h2a);
        write_reg(CFG_SET_BITS, 6'h06);
        write_reg(CFG_BLOCK_BITS, 6'h00);
        write_reg(CFG_WAYS_USED, 6'h30);
        send_access(MODE_LOAD, 64'h40);
        send_access(MODE_LOAD, 64'h80);
        send_access(MODE_STORE, 64'h40);
    endtask

    // Fill a four-way set, refresh one way, then force a replacement
    task automatic test_lru_replacement();
        settle();
        write_reg(CFG_SET_BITS, 6'h02);
        write_reg(CFG_BLOCK_BITS, 6'h04);
        write_reg(CFG_WAYS_USED, 6'h04);
        for (int t = 1; t <= 4; t++)
            send_access(MODE_LOAD, make_addr(64'(t), 1, 64'(t)));
        send_access(MODE_LOAD, make_addr(64'd1, 1, 64'd0));
        send_access(MODE_STORE, make_addr(64'd5, 1, 64'd15));
        send_access(MODE_MODIFY, make_addr(64'd2, 1, 64'd0));
    endtask

    // Phases of random settings with mostly well-formed set traffic
    task automatic test_random_traffic();
        logic [63:0] tag_pool[LINE_WAYS + 2];
        logic [CFG_DATA_W-1:0] word;
        logic [1:0] kind;
        logic [63:0] addr;
        int counted;
        int nsets;
        int nw;
        int set_idx;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            gaps_on = !(phase == 4 || phase == 5);
            // extremes in the first phases, random ones after
            word = CFG_DATA_W'($urandom);
            case (phase)
                0: word[SET_BITS_W-1:0] = 3'd0;
                1: word[SET_BITS_W-1:0] = 3'd7;
                2: word[SET_BITS_W-1:0] = 3'd6;
                default: ;
            endcase
            write_reg(CFG_SET_BITS, word);
            case (phase)
                0: word = 6'd0;
                1: word = 6'd63;
                2: word = 6'd58;
                default: word = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
            endcase
            write_reg(CFG_BLOCK_BITS, word);
            word = CFG_DATA_W'($urandom);
            case (phase)
                0: word[WAYS_USED_W-1:0] = 4'd8;
                1: word[WAYS_USED_W-1:0] = 4'd0;
                2: word[WAYS_USED_W-1:0] = 4'd15;
                3: word[WAYS_USED_W-1:0] = 4'd1;
                default: ;
            endcase
            write_reg(CFG_WAYS_USED, word);

            nsets = 1 << ((mdl_set_bits > SET_MAX) ? SET_MAX : int'(mdl_set_bits));
            nw = (mdl_ways == 0) ? 1 : ((mdl_ways > LINE_WAYS) ? LINE_WAYS : int'(mdl_ways));
            foreach (tag_pool[i])
                tag_pool[i] = {$urandom, $urandom};
            counted = 0;
            while (counted < PHASE_ACCESSES)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    case ($urandom_range(0, 9))
                        0: kind = MODE_INSTR;
                        1, 2, 3: kind = MODE_LOAD;
                        4, 5, 6: kind = MODE_STORE;
                        default: kind = MODE_MODIFY;
                    endcase
                    if (nsets > 4 && $urandom_range(0, 4) != 0)
                        set_idx = $urandom_range(0, 3);
                    else
                        set_idx = $urandom_range(0, nsets - 1);
                    addr = make_addr(tag_pool[$urandom_range(0, nw + 1)], set_idx,
                                     {$urandom, $urandom});
                end
                else
                begin
                    // noise: any kind, any address
                    kind = 2'($urandom);
                    addr = {$urandom, $urandom};
                end
                send_access(kind, addr);
                if (kind != MODE_INSTR)
                    counted++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_lru_replacement();
        test_random_traffic();

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
